/* hdl/rhsd_pkg.sv */
// Shared constants and types for the readout hit stream deframer.
package rhsd_pkg;

   localparam int COUNTER_WIDTH_DEF = 32;
   localparam int WORD_WIDTH        = 32;
   localparam int IDX_WIDTH         = 6;
   localparam int CHANNELS          = 1 << IDX_WIDTH;

   localparam logic [WORD_WIDTH-1:0] ROLLOVER_MARK = 32'h5c5c_5c5c;
   localparam logic [WORD_WIDTH-1:0] HEADER_MARK   = 32'h1c1c_1c1c;

   typedef enum logic [3:0] {
      PH_SEEK_ROLL = 4'b0001,
      PH_SEEK_HEAD = 4'b0010,
      PH_FRAME     = 4'b0100,
      PH_HITS      = 4'b1000
   } phase_type;

endpackage

/* hdl/readout_hit_stream_deframer.sv */
// Readout hit stream deframer: parses readout words into timestamped hits.
//
//   channel | direction | ports                                        | handshake
//   --------+-----------+----------------------------------------------+--------------
//   req     | in        | req_data_word, req_first_of_buffer           | req_valid / req_stall
//   rsp     | out       | rsp_hit_*, rsp_frame_value, rsp_rollover_value,
//           |           | rsp_channel_hits                             | rsp_valid / rsp_stall
//
// A word is taken in every cycle unless req_stall is raised. Each word passes
// through the input stage (where the per-channel counter memory is read), and
// a hit word then lands in the result register once that register is free.
// The single-port read of the counter memory plus a one-deep write bypass
// sets the pace of one word per cycle while the result is not stalled.
// Reset is synchronous; it clears the phase, the rollover count (to all ones),
// the frame number and the per-channel valid bits, so the counter table reads
// as zero without a clearing pass. A stalled result holds in the result
// register while a new word may still enter the empty input stage.
module readout_hit_stream_deframer #(
   parameter int COUNTER_WIDTH = rhsd_pkg::COUNTER_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic        req_first_of_buffer,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_hit_column,
   output logic [2:0]  rsp_hit_pixel,
   output logic [1:0]  rsp_hit_tdc,
   output logic [14:0] rsp_hit_coarse,
   output logic [8:0]  rsp_hit_fine,
   output logic [31:0] rsp_frame_value,
   output logic [31:0] rsp_rollover_value,
   output logic [31:0] rsp_channel_hits
);

   localparam int IDX_W = rhsd_pkg::IDX_WIDTH;
   localparam int CH_N  = rhsd_pkg::CHANNELS;
   localparam int CW    = COUNTER_WIDTH;

   // ---------------- input stage ----------------
   logic             s1_valid_ff;
   logic [31:0]      s1_word_ff;
   logic             s1_fob_ff;

   // counter memory read port, valid bit and write bypass captured with the word
   logic [CW-1:0]    cnt_mem [CH_N];
   logic [CW-1:0]    rd_mem_ff;
   logic             rd_vld_ff;
   logic             byp_ff;
   logic [CW-1:0]    byp_val_ff;
   logic [CH_N-1:0]  cnt_vld_ff;

   // ---------------- parse state ----------------
   rhsd_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [31:0]      roll_ff, roll_in;
   logic [31:0]      frame_ff, frame_in;

   // ---------------- result register ----------------
   logic             out_valid_ff;
   logic [2:0]       out_col_ff;
   logic [2:0]       out_pix_ff;
   logic [1:0]       out_tdc_ff;
   logic [14:0]      out_coarse_ff;
   logic [8:0]       out_fine_ff;
   logic [31:0]      out_frame_ff;
   logic [31:0]      out_roll_ff;
   logic [31:0]      out_hits_ff;

   logic             out_free;
   logic             s1_adv;
   logic             req_accept;
   logic             is_roll;
   logic             is_head;
   logic             is_hit;
   logic             wr_en;
   logic [IDX_W-1:0] s1_idx;
   logic [IDX_W-1:0] req_idx;
   logic [CW-1:0]    old_cnt;
   logic [CW-1:0]    new_cnt;
   logic [CW+31:0]   cnt_ext;

   // Handshake: the input stage drains whenever the result register is free.
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign s1_idx  = s1_word_ff[31:26];
   assign req_idx = req_data_word[31:26];

   // Start of buffer forces the rollover search before the word is examined.
   assign cur_phase = s1_fob_ff ? rhsd_pkg::PH_SEEK_ROLL : phase_ff;
   assign is_roll   = (s1_word_ff == rhsd_pkg::ROLLOVER_MARK);
   assign is_head   = (s1_word_ff == rhsd_pkg::HEADER_MARK);

   // Phase sequencing: markers advance, the word after a header is the frame.
   always_comb begin
      phase_in = cur_phase;
      roll_in  = roll_ff;
      frame_in = frame_ff;
      is_hit   = 1'b0;
      unique case (cur_phase)
         rhsd_pkg::PH_SEEK_ROLL: begin
            if (is_roll) begin
               roll_in  = roll_ff + 32'd1;
               phase_in = rhsd_pkg::PH_SEEK_HEAD;
            end
         end
         rhsd_pkg::PH_SEEK_HEAD: begin
            if (is_head) begin
               phase_in = rhsd_pkg::PH_FRAME;
            end
         end
         rhsd_pkg::PH_FRAME: begin
            frame_in = s1_word_ff;
            phase_in = rhsd_pkg::PH_HITS;
         end
         rhsd_pkg::PH_HITS: begin
            // A rollover marker among hits closes the frame; anything else is a hit.
            if (is_roll) begin
               roll_in  = roll_ff + 32'd1;
               phase_in = rhsd_pkg::PH_SEEK_HEAD;
            end else begin
               is_hit = 1'b1;
            end
         end
         default: begin
            phase_in = rhsd_pkg::PH_SEEK_ROLL;
         end
      endcase
   end

   // Counter update: bypass wins over the memory, an unwritten entry reads zero.
   assign old_cnt = byp_ff ? byp_val_ff : (rd_vld_ff ? rd_mem_ff : '0);
   assign new_cnt = old_cnt + CW'(1);
   assign wr_en   = s1_adv && is_hit;
   assign cnt_ext = {32'd0, new_cnt};

   // Input stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Input stage payload plus the memory read for the incoming word
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_word_ff <= req_data_word;
         s1_fob_ff  <= req_first_of_buffer;
         rd_mem_ff  <= cnt_mem[req_idx];
         rd_vld_ff  <= cnt_vld_ff[req_idx];
         // The word leaving this cycle may write the same channel.
         byp_ff     <= wr_en && (s1_idx == req_idx);
         byp_val_ff <= new_cnt;
      end
   end

   // Counter memory write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[s1_idx] <= new_cnt;
      end
   end

   // Per-channel valid bits stand in for clearing the table
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
      end else if (wr_en) begin
         cnt_vld_ff[s1_idx] <= 1'b1;
      end
   end

   // Parse state advances once per word leaving the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rhsd_pkg::PH_SEEK_ROLL;
         roll_ff  <= '1;
         frame_ff <= '0;
      end else if (s1_adv) begin
         phase_ff <= phase_in;
         roll_ff  <= roll_in;
         frame_ff <= frame_in;
      end
   end

   // Result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_adv && is_hit;
      end
   end

   // Result register payload: unpack the hit word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         out_col_ff    <= s1_word_ff[31:29];
         out_pix_ff    <= s1_word_ff[28:26];
         out_tdc_ff    <= s1_word_ff[25:24];
         out_coarse_ff <= s1_word_ff[23:9];
         out_fine_ff   <= s1_word_ff[8:0];
         out_frame_ff  <= frame_ff;
         out_roll_ff   <= roll_ff;
         out_hits_ff   <= cnt_ext[31:0];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_hit_column     = out_col_ff;
   assign rsp_hit_pixel      = out_pix_ff;
   assign rsp_hit_tdc        = out_tdc_ff;
   assign rsp_hit_coarse     = out_coarse_ff;
   assign rsp_hit_fine       = out_fine_ff;
   assign rsp_frame_value    = out_frame_ff;
   assign rsp_rollover_value = out_roll_ff;
   assign rsp_channel_hits   = out_hits_ff;

endmodule

/* hdl/rhsd_checker.sv */
// Port-level checker for the readout hit stream deframer, with its bind.
module rhsd_checker #(
   parameter int COUNTER_WIDTH = rhsd_pkg::COUNTER_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [31:0] req_data_word,
   input logic        req_first_of_buffer,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_hit_column,
   input logic [2:0]  rsp_hit_pixel,
   input logic [1:0]  rsp_hit_tdc,
   input logic [14:0] rsp_hit_coarse,
   input logic [8:0]  rsp_hit_fine,
   input logic [31:0] rsp_frame_value,
   input logic [31:0] rsp_rollover_value,
   input logic [31:0] rsp_channel_hits
);

   localparam logic [63:0] CNT_MASK64 = (COUNTER_WIDTH >= 64) ? '1 :
                                        ((64'd1 << COUNTER_WIDTH) - 64'd1);
   localparam logic [31:0] HIT_MASK   = CNT_MASK64[31:0];

   logic rsp_take;
   assign rsp_take = rsp_valid && !rsp_stall;

   // Input backs up only behind a stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   // Nothing comes out right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds its count.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_channel_hits)))
      else $error("stalled result changed");

   // Back-to-back hits on one channel count up by one.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take ##1 (rsp_take && rsp_hit_column == $past(rsp_hit_column)
                    && rsp_hit_pixel == $past(rsp_hit_pixel))
      |-> rsp_channel_hits == (($past(rsp_channel_hits) + 32'd1) & HIT_MASK))
      else $error("channel count did not step by one");

   // A new frame always follows a rollover marker.
   a_frame_roll: assert property (@(posedge clock) disable iff (reset)
      rsp_take ##1 (rsp_take && rsp_rollover_value == $past(rsp_rollover_value))
      |-> rsp_frame_value == $past(rsp_frame_value))
      else $error("frame changed without a rollover");

endmodule

bind readout_hit_stream_deframer rhsd_checker #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_rhsd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_data_word      (req_data_word),
   .req_first_of_buffer(req_first_of_buffer),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_hit_column     (rsp_hit_column),
   .rsp_hit_pixel      (rsp_hit_pixel),
   .rsp_hit_tdc        (rsp_hit_tdc),
   .rsp_hit_coarse     (rsp_hit_coarse),
   .rsp_hit_fine       (rsp_hit_fine),
   .rsp_frame_value    (rsp_frame_value),
   .rsp_rollover_value (rsp_rollover_value),
   .rsp_channel_hits   (rsp_channel_hits)
);
